// ===== rtl/tld_pkg.sv =====
// Shared types, codes and constants of the terminal line discipline.
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

   // Line buffer geometry and register port widths
   localparam int LINE_DEPTH_DEF = 32;
   localparam int FILL_W         = 6;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 8;

   // Request operation codes
   localparam logic OP_INPUT  = 1'b0;
   localparam logic OP_OUTPUT = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_READER  = 2'd0;
   localparam logic [1:0] KIND_DISPLAY = 2'd1;
   localparam logic [1:0] KIND_REFUSED = 2'd2;

   // What follows the display bytes of a request
   localparam logic [1:0] TAIL_NONE  = 2'd0;
   localparam logic [1:0] TAIL_ONE   = 2'd1;
   localparam logic [1:0] TAIL_FLUSH = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CANONICAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ECHO      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OPOST     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NL_CRNL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CR_NL     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IN_XLATE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ERASE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_EOF       = 3'd7;

   // Character constants
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       canonical_mode;
      logic       echo_enable;
      logic       output_post;
      logic       map_nl_to_crnl;
      logic       map_cr_to_nl;
      logic [1:0] input_translate;
      logic [7:0] erase_char;
      logic [7:0] eof_char;
   } cfg_type;

   // Work list decoded from one request
   typedef struct packed {
      logic [1:0]        disp_cnt;
      logic [7:0]        disp0;
      logic [7:0]        disp1;
      logic [7:0]        disp2;
      logic [1:0]        tail;
      logic [1:0]        one_kind;
      logic [7:0]        one_byte;
      logic              wr_en;
      logic [7:0]        wr_byte;
      logic [FILL_W-1:0] fill_next;
      logic [FILL_W-1:0] flush_cnt;
   } plan_type;

endpackage

`default_nettype wire

// ===== rtl/tty_line_discipline.sv =====
// Terminal line discipline top level: registers, line buffer and result sequencer.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_data.op, req_data.data
//   rsp      out        rsp_valid/rsp_stall   rsp_data.kind, .out_byte, .last
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// A request is taken while idle, then the sequencer sends one result per cycle
// for display bytes and refusals, and sends each reader byte of a line flush
// after a buffer RAM read (ST_READ, then ST_SEND).
// Reset restores register defaults and empties the line; the buffer is not cleared.
// A stalled result register holds the sequencer; a new request waits for idle.
`timescale 1ns / 1ps
`default_nettype none

module tty_line_discipline
   import tld_pkg::*;
#(
   parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(LINE_DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DISP = 3'd1;
   localparam logic [2:0] ST_ONE  = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_SEND = 3'd4;

   cfg_type           cfg_ff, cfg_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [2:0]        state_ff, state_in;
   plan_type          plan_ff, plan_in;
   plan_type          plan_dec;
   logic [1:0]        didx_ff, didx_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [7:0]        rd_byte;
   logic              accept;
   logic              out_free;
   logic              disp_done;
   logic [7:0]        disp_byte;
   logic [FILL_W-1:0] idx_inc;
   logic [2:0]        after_disp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Decode the incoming request
   tld_decode #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_decode (
      .req  (req_data),
      .cfg  (cfg_ff),
      .fill (fill_ff),
      .plan (plan_dec)
   );

   // Line buffer: written at accept, read during a flush
   tld_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept && plan_dec.wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (plan_dec.wr_byte),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_byte)
   );

   // Apply register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_CANONICAL: cfg_in.canonical_mode  = csr_wdata[0];
            REG_ECHO:      cfg_in.echo_enable     = csr_wdata[0];
            REG_OPOST:     cfg_in.output_post     = csr_wdata[0];
            REG_NL_CRNL:   cfg_in.map_nl_to_crnl  = csr_wdata[0];
            REG_CR_NL:     cfg_in.map_cr_to_nl    = csr_wdata[0];
            REG_IN_XLATE:  cfg_in.input_translate = csr_wdata[1:0];
            REG_ERASE:     cfg_in.erase_char      = csr_wdata;
            REG_EOF:       cfg_in.eof_char        = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Select the pending display byte
   always_comb begin
      case (didx_ff)
         2'd0:    disp_byte = plan_ff.disp0;
         2'd1:    disp_byte = plan_ff.disp1;
         default: disp_byte = plan_ff.disp2;
      endcase
   end

   assign disp_done = didx_ff == (plan_ff.disp_cnt - 2'd1);
   assign idx_inc   = idx_ff + FILL_W'(1);

   always_comb begin
      case (plan_ff.tail)
         TAIL_ONE:   after_disp = ST_ONE;
         TAIL_FLUSH: after_disp = ST_READ;
         default:    after_disp = ST_IDLE;
      endcase
   end

   // Sequence the results of one request
   always_comb begin
      state_in     = state_ff;
      plan_in      = plan_ff;
      didx_in      = didx_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               plan_in = plan_dec;
               fill_in = plan_dec.fill_next;
               didx_in = 2'd0;
               idx_in  = '0;
               if (plan_dec.disp_cnt != 2'd0) begin
                  state_in = ST_DISP;
               end else if (plan_dec.tail == TAIL_ONE) begin
                  state_in = ST_ONE;
               end else if (plan_dec.tail == TAIL_FLUSH) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_DISP: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_DISPLAY;
               rsp_in.out_byte = disp_byte;
               rsp_in.last     = disp_done && plan_ff.tail == TAIL_NONE;
               if (disp_done) begin
                  state_in = after_disp;
               end else begin
                  didx_in = didx_ff + 2'd1;
               end
            end
         end
         ST_ONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = plan_ff.one_kind;
               rsp_in.out_byte = plan_ff.one_byte;
               rsp_in.last     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_READER;
               rsp_in.out_byte = rd_byte;
               rsp_in.last     = idx_inc == plan_ff.flush_cnt;
               if (idx_inc == plan_ff.flush_cnt) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                   <= ST_IDLE;
         fill_ff                    <= '0;
         rsp_valid_ff               <= 1'b0;
         cfg_ff.canonical_mode      <= 1'b1;
         cfg_ff.echo_enable         <= 1'b1;
         cfg_ff.output_post         <= 1'b1;
         cfg_ff.map_nl_to_crnl      <= 1'b1;
         cfg_ff.map_cr_to_nl        <= 1'b0;
         cfg_ff.input_translate     <= 2'd2;
         cfg_ff.erase_char          <= 8'd127;
         cfg_ff.eof_char            <= 8'd4;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Hold payload state
   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      didx_ff <= didx_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   // Line never grows past the buffer
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(LINE_DEPTH))
      else $error("line fill exceeds buffer depth");

   // Flush index stays inside the line being sent
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (idx_ff < plan_ff.flush_cnt))
      else $error("flush index past line length");

   // A buffer read is always followed by its send
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_SEND))
      else $error("buffer read not followed by send");

   // A stalled result register freezes the sequencer
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DISP || state_ff == ST_ONE || state_ff == ST_SEND)
       && rsp_valid_ff && rsp_stall) |=> (state_ff == $past(state_ff)))
      else $error("sequencer advanced under stall");

endmodule

`default_nettype wire

// ===== rtl/tld_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write when enabled; read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tld_decode.sv =====
// Request classifier: turns one byte into the list of results to send.
`timescale 1ns / 1ps
`default_nettype none

module tld_decode
   import tld_pkg::*;
#(
   parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
   input  wire req_type      req,
   input  wire cfg_type      cfg,
   input  wire logic [FILL_W-1:0] fill,
   output plan_type          plan
);

   // Output postprocessing of one byte: {count, first, second}
   function automatic logic [17:0] map_out(input logic [7:0] c, input cfg_type k,
                                           input logic post);
      logic [17:0] r;
      begin
         r = {2'd1, c, 8'd0};
         if (post && c == CH_LF && k.map_nl_to_crnl) begin
            r = {2'd2, CH_CR, CH_LF};
         end else if (post && c == CH_CR && k.map_cr_to_nl) begin
            r = {2'd1, CH_LF, 8'd0};
         end
         map_out = r;
      end
   endfunction

   logic        full;
   logic        xl_nl;
   logic        xl_cr;
   logic        xlated;
   logic [7:0]  c1;
   logic [7:0]  cs;
   logic        hit_erase;
   logic        hit_eof;
   logic        is_erase;
   logic        is_eof;
   logic [17:0] map_req;
   logic [17:0] map_store;

   // Classify the byte: one translation at most, then compare again
   assign full      = fill >= FILL_W'(LINE_DEPTH);
   assign xl_nl     = req.data == CH_LF && cfg.input_translate[0];
   assign xl_cr     = req.data == CH_CR && cfg.input_translate[1];
   assign xlated    = xl_nl || xl_cr;
   assign c1        = xl_nl ? CH_CR : (xl_cr ? CH_LF : req.data);
   assign cs        = (c1 == CH_ESC) ? CH_CARET : c1;
   assign hit_erase = req.data == cfg.erase_char;
   assign hit_eof   = req.data == cfg.eof_char;
   assign is_erase  = hit_erase || (!hit_eof && xlated && c1 == cfg.erase_char);
   assign is_eof    = !is_erase && (hit_eof || (xlated && c1 == cfg.eof_char));
   assign map_req   = map_out(req.data, cfg, cfg.output_post);
   assign map_store = map_out(cs, cfg, cfg.output_post);

   // Build the work list
   always_comb begin
      plan           = '0;
      plan.tail      = TAIL_NONE;
      plan.one_kind  = KIND_READER;
      plan.fill_next = fill;
      if (req.op == OP_OUTPUT) begin
         plan.disp_cnt = map_req[17:16];
         plan.disp0    = map_req[15:8];
         plan.disp1    = map_req[7:0];
      end else if (!cfg.canonical_mode) begin
         plan.disp_cnt = cfg.echo_enable ? 2'd1 : 2'd0;
         plan.disp0    = req.data;
         plan.tail     = TAIL_ONE;
         plan.one_byte = req.data;
      end else if (full) begin
         plan.tail     = TAIL_ONE;
         plan.one_kind = KIND_REFUSED;
      end else if (is_erase) begin
         if (fill != '0) begin
            plan.fill_next = fill - FILL_W'(1);
            if (cfg.echo_enable) begin
               plan.disp_cnt = 2'd3;
               plan.disp0    = CH_BS;
               plan.disp1    = CH_SP;
               plan.disp2    = CH_BS;
            end
         end
      end else if (is_eof) begin
         if (fill != '0) begin
            plan.tail      = TAIL_FLUSH;
            plan.flush_cnt = fill;
            plan.fill_next = '0;
         end
      end else begin
         plan.wr_en     = 1'b1;
         plan.wr_byte   = cs;
         plan.fill_next = fill + FILL_W'(1);
         if (cfg.echo_enable) begin
            plan.disp_cnt = map_store[17:16];
            plan.disp0    = map_store[15:8];
            plan.disp1    = map_store[7:0];
         end
         if (cs == CH_LF) begin
            plan.tail      = TAIL_FLUSH;
            plan.flush_cnt = fill + FILL_W'(1);
            plan.fill_next = '0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_tty_line_discipline.sv =====
// Self-checking testbench of the terminal line discipline: directed table, random lines, overflow.
`timescale 1ns / 1ps

module tb_tty_line_discipline;
   import tld_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 16;
   localparam int NUM_DIRECTED  = 21;

   // Idling schemes: sender-light, receiver-light, none
   localparam int IDLE_SEND_LIGHT = 0;
   localparam int IDLE_RECV_LIGHT = 1;
   localparam int IDLE_NONE       = 2;

   localparam cfg_type RESET_CFG = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 2'd2, 8'd127, 8'd4};

   typedef rsp_type rsp_q_type [$];

   // Shadow of the block: registers, line buffer and fill level
   typedef struct packed {
      cfg_type                        cfg;
      logic [LINE_DEPTH_DEF-1:0][7:0] line;
      logic [FILL_W-1:0]              fill;
   } disc_state_type;

   typedef struct packed {
      req_type rq;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   disc_state_type line_st;
   rsp_q_type      due_results;
   dir_row_type    dir_tbl [NUM_DIRECTED];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          error_count;
   int          items_sent;
   int          results_seen;
   int          cfg_settings;
   int          cycle_count;

   tty_line_discipline u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Push one display byte, applying the output mapping when post is set
   function automatic void put_display(inout rsp_q_type q, input logic [7:0] b,
                                       input logic post, input cfg_type c);
      if (post && b == CH_LF && c.map_nl_to_crnl) begin
         q.push_back(rsp_type'{KIND_DISPLAY, CH_CR, 1'b0});
         q.push_back(rsp_type'{KIND_DISPLAY, CH_LF, 1'b0});
      end else if (post && b == CH_CR && c.map_cr_to_nl) begin
         q.push_back(rsp_type'{KIND_DISPLAY, CH_LF, 1'b0});
      end else begin
         q.push_back(rsp_type'{KIND_DISPLAY, b, 1'b0});
      end
   endfunction

   // Hand the buffered line to the reader and empty it
   function automatic void line_flush(inout disc_state_type st, inout rsp_q_type q);
      for (int i = 0; i < st.fill; i++)
         q.push_back(rsp_type'{KIND_READER, st.line[i], 1'b0});
      st.fill = '0;
   endfunction

   // Results of one request, advancing the shadow state
   function automatic void discipline_step(inout disc_state_type st, input req_type rq,
                                           output rsp_q_type res);
      logic [7:0] ch;
      logic       done;
      res  = {};
      ch   = rq.data;
      done = 1'b0;
      if (rq.op == OP_OUTPUT) begin
         put_display(res, ch, st.cfg.output_post, st.cfg);
      end else if (!st.cfg.canonical_mode) begin
         if (st.cfg.echo_enable)
            res.push_back(rsp_type'{KIND_DISPLAY, ch, 1'b0});
         res.push_back(rsp_type'{KIND_READER, ch, 1'b0});
      end else if (st.fill >= LINE_DEPTH_DEF) begin
         res.push_back(rsp_type'{KIND_REFUSED, 8'h00, 1'b0});
      end else begin
         // second pass rechecks a translated byte but never translates again
         for (int pass = 0; pass < 2; pass++) begin
            if (!done) begin
               if (ch == st.cfg.erase_char) begin
                  if (st.fill != 0) begin
                     st.fill = st.fill - 1'b1;
                     if (st.cfg.echo_enable) begin
                        put_display(res, CH_BS, st.cfg.output_post, st.cfg);
                        put_display(res, CH_SP, st.cfg.output_post, st.cfg);
                        put_display(res, CH_BS, st.cfg.output_post, st.cfg);
                     end
                  end
                  done = 1'b1;
               end else if (ch == st.cfg.eof_char) begin
                  if (st.fill != 0)
                     line_flush(st, res);
                  done = 1'b1;
               end else if (pass == 0 && ch == CH_LF && st.cfg.input_translate[0]) begin
                  ch = CH_CR;
               end else if (pass == 0 && ch == CH_CR && st.cfg.input_translate[1]) begin
                  ch = CH_LF;
               end
            end
         end
         if (!done) begin
            if (ch == CH_ESC)
               ch = CH_CARET;
            if (st.cfg.echo_enable)
               put_display(res, ch, st.cfg.output_post, st.cfg);
            st.line[st.fill] = ch;
            st.fill = st.fill + 1'b1;
            if (ch == CH_LF)
               line_flush(st, res);
         end
      end
      if (res.size() != 0)
         res[res.size()-1].last = 1'b1;
   endfunction

   // Offer one request, hold it until taken, then queue what it should produce
   task automatic send_req(input req_type rq, input logic typed, input rsp_type typed_rsp);
      rsp_q_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      discipline_step(line_st, rq, res);
      if (typed)
         res = '{typed_rsp};
      foreach (res[i])
         due_results.push_back(res[i]);
      items_sent++;
      @(negedge clock);
   endtask

   // Keyboard byte; swap in the erase byte where it would otherwise fill the line
   task automatic send_key(input logic [7:0] b);
      disc_state_type trial;
      rsp_q_type      scratch;
      req_type        rq;
      rq    = '{OP_INPUT, b};
      trial = line_st;
      discipline_step(trial, rq, scratch);
      if (trial.fill >= LINE_DEPTH_DEF)
         rq.data = line_st.cfg.erase_char;
      send_req(rq, 1'b0, '0);
   endtask

   // Hold off new requests until every queued result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (due_results.size() != 0)
         @(negedge clock);
   endtask

   // Program all registers while the block is idle
   task automatic apply_cfg(input cfg_type c);
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      for (int i = 0; i < 8; i++) begin
         idx = CSR_IDX_W'(i);
         case (idx)
            REG_CANONICAL: val = CSR_DATA_W'(c.canonical_mode);
            REG_ECHO:      val = CSR_DATA_W'(c.echo_enable);
            REG_OPOST:     val = CSR_DATA_W'(c.output_post);
            REG_NL_CRNL:   val = CSR_DATA_W'(c.map_nl_to_crnl);
            REG_CR_NL:     val = CSR_DATA_W'(c.map_cr_to_nl);
            REG_IN_XLATE:  val = CSR_DATA_W'(c.input_translate);
            REG_ERASE:     val = c.erase_char;
            default:       val = c.eof_char;
         endcase
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_wdata    <= val;
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
      line_st.cfg = c;
      cfg_settings++;
   endtask

   function automatic void set_idling(input int mode);
      case (mode)
         IDLE_SEND_LIGHT: begin send_idle_pct = 26; recv_idle_pct = 86; end
         IDLE_RECV_LIGHT: begin send_idle_pct = 86; recv_idle_pct = 26; end
         default:         begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
   endfunction

   // Bytes the discipline treats specially under the current setting
   function automatic logic [7:0] pick_special();
      case ($urandom_range(7))
         0: pick_special = line_st.cfg.erase_char;
         1: pick_special = line_st.cfg.eof_char;
         2: pick_special = CH_LF;
         3: pick_special = CH_CR;
         4: pick_special = CH_ESC;
         5: pick_special = 8'h00;
         6: pick_special = 8'hFF;
         default: pick_special = 8'($urandom_range(255));
      endcase
   endfunction

   // Random phase: mostly whole lines, plus program output and stray keys
   task automatic run_phase(input cfg_type c, input int mode);
      int         start;
      int         pick;
      int         len;
      int         r;
      logic [7:0] b;
      apply_cfg(c);
      set_idling(mode);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(31, 20) : $urandom_range(8);
            for (int k = 0; k < len; k++) begin
               r = $urandom_range(99);
               if (r < 70)      b = 8'($urandom_range(8'h7E, 8'h20));
               else if (r < 82) b = line_st.cfg.erase_char;
               else if (r < 88) b = CH_ESC;
               else             b = 8'($urandom_range(255));
               send_key(b);
            end
            case ($urandom_range(2))
               0:       send_key(CH_LF);
               1:       send_key(CH_CR);
               default: send_key(line_st.cfg.eof_char);
            endcase
         end else if (pick < 80) begin
            b = $urandom_range(1) ? pick_special() : 8'($urandom_range(255));
            send_req('{OP_OUTPUT, b}, 1'b0, '0);
         end else if (pick < 97) begin
            send_key($urandom_range(1) ? pick_special() : 8'($urandom_range(255)));
         end else begin
            drain_results();
         end
      end
   endtask

   // Receiver stalls at random
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // Check each delivered result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (due_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected result kind=%0d byte=%02h last=%0d", $time,
                        rsp_data.kind, rsp_data.out_byte, rsp_data.last);
         end else begin
            want = due_results.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
                rsp_data.last !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display({"%0t: mismatch expected kind=%0d byte=%02h last=%0d,",
                            " got kind=%0d byte=%02h last=%0d"},
                           $time, want.kind, want.out_byte, want.last,
                           rsp_data.kind, rsp_data.out_byte, rsp_data.last);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      cfg_type c;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_write_en  = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      error_count   = 0;
      items_sent    = 0;
      results_seen  = 0;
      cfg_settings  = 0;
      cycle_count   = 0;
      line_st       = '0;
      line_st.cfg   = RESET_CFG;

      // Directed requests under the reset setting
      dir_tbl = '{
         '{'{OP_OUTPUT, 8'h41},   1'b1, '{KIND_DISPLAY, 8'h41, 1'b1}},
         '{'{OP_OUTPUT, 8'h00},   1'b1, '{KIND_DISPLAY, 8'h00, 1'b1}},
         '{'{OP_OUTPUT, 8'hFF},   1'b1, '{KIND_DISPLAY, 8'hFF, 1'b1}},
         '{'{OP_OUTPUT, CH_LF},   1'b0, '0},
         '{'{OP_OUTPUT, CH_CR},   1'b1, '{KIND_DISPLAY, CH_CR, 1'b1}},
         '{'{OP_INPUT,  8'h7F},   1'b0, '0},
         '{'{OP_INPUT,  8'h04},   1'b0, '0},
         '{'{OP_INPUT,  8'h68},   1'b1, '{KIND_DISPLAY, 8'h68, 1'b1}},
         '{'{OP_INPUT,  8'hFF},   1'b1, '{KIND_DISPLAY, 8'hFF, 1'b1}},
         '{'{OP_INPUT,  8'h00},   1'b1, '{KIND_DISPLAY, 8'h00, 1'b1}},
         '{'{OP_INPUT,  CH_ESC},  1'b0, '0},
         '{'{OP_INPUT,  8'h7F},   1'b0, '0},
         '{'{OP_INPUT,  CH_CR},   1'b0, '0},
         '{'{OP_INPUT,  8'h78},   1'b1, '{KIND_DISPLAY, 8'h78, 1'b1}},
         '{'{OP_INPUT,  8'h04},   1'b0, '0},
         '{'{OP_INPUT,  CH_LF},   1'b0, '0},
         '{'{OP_INPUT,  8'h71},   1'b1, '{KIND_DISPLAY, 8'h71, 1'b1}},
         '{'{OP_INPUT,  CH_ESC},  1'b0, '0},
         '{'{OP_INPUT,  8'h04},   1'b0, '0},
         '{'{OP_OUTPUT, CH_BS},   1'b1, '{KIND_DISPLAY, CH_BS, 1'b1}},
         '{'{OP_OUTPUT, CH_ESC},  1'b1, '{KIND_DISPLAY, CH_ESC, 1'b1}}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idling(IDLE_SEND_LIGHT);
      foreach (dir_tbl[i])
         send_req(dir_tbl[i].rq, dir_tbl[i].typed, dir_tbl[i].want);

      // Random phases over a spread of settings
      run_phase(RESET_CFG, IDLE_SEND_LIGHT);
      run_phase('{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 2'd1, 8'h00, 8'hFF}, IDLE_SEND_LIGHT);
      run_phase('{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 2'd3, 8'hFF, 8'h00}, IDLE_RECV_LIGHT);
      c = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 2'd3, 8'($urandom_range(255)),
            8'($urandom_range(255))};
      run_phase(c, IDLE_RECV_LIGHT);
      // erase and end-of-file on one byte: erase wins
      run_phase('{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 8'h15, 8'h15}, IDLE_RECV_LIGHT);
      c = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 2'd3, 8'($urandom_range(255)),
            8'($urandom_range(255))};
      run_phase(c, IDLE_NONE);
      run_phase('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 8'h7F, 8'h04}, IDLE_NONE);

      // Fill the line to capacity; from then on every keyboard byte in canonical mode is refused
      apply_cfg(RESET_CFG);
      set_idling(IDLE_NONE);
      while (line_st.fill < LINE_DEPTH_DEF)
         send_req('{OP_INPUT, 8'h41 + 8'(line_st.fill % 26)}, 1'b0, '0);
      send_req('{OP_INPUT, 8'h7F},  1'b1, '{KIND_REFUSED, 8'h00, 1'b1});
      send_req('{OP_INPUT, 8'h04},  1'b1, '{KIND_REFUSED, 8'h00, 1'b1});
      send_req('{OP_INPUT, CH_LF},  1'b1, '{KIND_REFUSED, 8'h00, 1'b1});
      send_req('{OP_INPUT, CH_CR},  1'b1, '{KIND_REFUSED, 8'h00, 1'b1});
      send_req('{OP_INPUT, CH_ESC}, 1'b1, '{KIND_REFUSED, 8'h00, 1'b1});
      send_req('{OP_INPUT, 8'h00},  1'b1, '{KIND_REFUSED, 8'h00, 1'b1});
      send_req('{OP_INPUT, 8'hFF},  1'b1, '{KIND_REFUSED, 8'h00, 1'b1});
      send_req('{OP_OUTPUT, CH_LF}, 1'b0, '0);
      send_req('{OP_OUTPUT, 8'h5A}, 1'b1, '{KIND_DISPLAY, 8'h5A, 1'b1});
      // raw mode still forwards while the line stays full
      apply_cfg('{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 2'd2, 8'd127, 8'd4});
      send_req('{OP_INPUT, 8'h72}, 1'b0, '0);
      send_req('{OP_INPUT, CH_LF}, 1'b0, '0);
      apply_cfg(RESET_CFG);
      send_req('{OP_INPUT, 8'h72}, 1'b1, '{KIND_REFUSED, 8'h00, 1'b1});

      // Let the last results drain, then allow for stragglers
      req_valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Sent %0d requests under %0d register settings, %0d results checked.",
               items_sent, cfg_settings, results_seen);
      $display("Covered echo, erase, end-of-file, CR/LF mapping, ESC, raw mode and refusal.");
      if (error_count == 0 && due_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tld_pkg.sv
rtl/tld_ram.sv
rtl/tld_decode.sv
rtl/tty_line_discipline.sv
tb/tb_tty_line_discipline.sv
